[sv/gaes_pkg.sv]
// ----------------------------------------------------------------------------
// Grouped array element-wise sum: shared package
// Widths, item types, command codes and state encoding for the core.
// ----------------------------------------------------------------------------
package gaes_pkg;

  localparam int GROUPS  = 256;
  localparam int MAX_LEN = 16;

  localparam int GRP_W   = $clog2(GROUPS);
  localparam int POS_W   = $clog2(MAX_LEN + 1);
  localparam int SLOTS   = GROUPS * MAX_LEN;
  localparam int SLOT_AW = $clog2(SLOTS);
  localparam int VAL_W   = 64;

  localparam logic [1:0] KIND_ADD   = 2'd0;
  localparam logic [1:0] KIND_EMPTY = 2'd1;
  localparam logic [1:0] KIND_READ  = 2'd2;

  typedef struct packed {
    logic [1:0]              kind;
    logic [7:0]              group_id;
    logic signed [VAL_W-1:0] elem_value;
    logic                    elem_is_null;
    logic                    elem_last;
  } in_item_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] out_value;
    logic                    out_is_null;
    logic                    group_is_null;
    logic                    out_last;
    logic                    status;
  } out_item_t;

  typedef struct packed {
    logic [POS_W-1:0] len;
    logic [POS_W-1:0] pos;
    logic             first;
  } meta_t;

  typedef struct packed {
    logic             is_null;
    logic [VAL_W-1:0] sum;
  } slot_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_META,
    ST_SLOT,
    ST_READ
  } state_t;

  function automatic logic [SLOT_AW-1:0] slot_addr(input logic [GRP_W-1:0] g,
                                                   input logic [POS_W-1:0] p);
    slot_addr = SLOT_AW'(g) * SLOT_AW'(MAX_LEN) + SLOT_AW'(p);
  endfunction

endpackage

[sv/gaes_ram.sv]
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module gaes_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

[sv/grouped_array_elementwise_sum_core.sv]
// ----------------------------------------------------------------------------
// Grouped array element-wise sum core
// Per-group element-wise 64-bit sums of arrays with null handling.
// ----------------------------------------------------------------------------
// An add item passes through ST_META, and also through ST_SLOT when a later
// array adds an accepted non-null element, as the slot sum is read from RAM
// before it is written back; its acknowledgment is registered in the last state.
// A non-empty read goes from ST_META to ST_READ, which emits results at one
// per cycle; a null read ends in ST_META. The receiver cannot stall results.
// Reset clears the controller and the per-group presence flags; no RAM clearing.
module grouped_array_elementwise_sum_core import gaes_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  in_item_t  in_item,
  output logic      out_valid,
  output out_item_t out_item
);

  state_t            state_r, state_nxt;
  in_item_t          item_r, item_nxt;
  logic [GROUPS-1:0] has_r, has_nxt;
  logic [POS_W-1:0]  idx_r, idx_nxt;
  logic [POS_W-1:0]  len_r, len_nxt;
  logic [SLOT_AW-1:0] saddr_r, saddr_nxt;
  logic              out_valid_r, out_valid_nxt;
  out_item_t         out_item_r, out_item_nxt;

  logic               meta_we;
  meta_t              meta_wdata;
  logic [$bits(meta_t)-1:0] meta_rbits;
  meta_t              meta_rd;
  logic               slot_we;
  logic [SLOT_AW-1:0] slot_waddr;
  slot_t              slot_wdata;
  logic [SLOT_AW-1:0] slot_raddr;
  logic [$bits(slot_t)-1:0] slot_rbits;
  slot_t              slot_rd;

  assign meta_rd = meta_t'(meta_rbits);
  assign slot_rd = slot_t'(slot_rbits);

  gaes_ram #(
    .WIDTH ($bits(meta_t)),
    .DEPTH (GROUPS)
  ) u_meta_ram (
    .clk   (clk),
    .we    (meta_we),
    .waddr (item_r.group_id[GRP_W-1:0]),
    .wdata (meta_wdata),
    .raddr (in_item.group_id[GRP_W-1:0]),
    .rdata (meta_rbits)
  );

  gaes_ram #(
    .WIDTH ($bits(slot_t)),
    .DEPTH (SLOTS)
  ) u_slot_ram (
    .clk   (clk),
    .we    (slot_we),
    .waddr (slot_waddr),
    .wdata (slot_wdata),
    .raddr (slot_raddr),
    .rdata (slot_rbits)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      has_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      has_r       <= has_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r     <= item_nxt;
    idx_r      <= idx_nxt;
    len_r      <= len_nxt;
    saddr_r    <= saddr_nxt;
    out_item_r <= out_item_nxt;
  end

  always_comb begin
    logic [GRP_W-1:0] g;
    logic             cur_has;
    logic             cur_first;
    logic [POS_W-1:0] pos;
    logic [POS_W-1:0] pos_new;
    logic [POS_W-1:0] len_new;
    logic             accept;
    logic             rd_last;

    g         = item_r.group_id[GRP_W-1:0];
    cur_has   = has_r[g];
    cur_first = cur_has && meta_rd.first;
    pos       = cur_has ? meta_rd.pos : '0;
    pos_new   = pos;
    len_new   = meta_rd.len;
    accept    = 1'b0;
    rd_last   = (idx_r + POS_W'(1)) == len_r;

    state_nxt     = state_r;
    item_nxt      = item_r;
    has_nxt       = has_r;
    idx_nxt       = idx_r;
    len_nxt       = len_r;
    saddr_nxt     = saddr_r;
    out_valid_nxt = 1'b0;
    out_item_nxt  = '0;
    meta_we       = 1'b0;
    meta_wdata    = '0;
    slot_we       = 1'b0;
    slot_waddr    = saddr_r;
    slot_wdata    = '0;
    slot_raddr    = saddr_r;

    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          item_nxt  = in_item;
          state_nxt = ST_META;
        end
      end

      ST_META: begin
        state_nxt = ST_IDLE;
        case (item_r.kind)
          KIND_ADD: begin
            out_item_nxt.out_last = 1'b1;
            has_nxt[g]            = 1'b1;
            meta_we               = 1'b1;
            if (!cur_has || cur_first) begin
              if (pos < POS_W'(MAX_LEN)) begin
                slot_we            = 1'b1;
                slot_waddr         = slot_addr(g, pos);
                slot_wdata.is_null = item_r.elem_is_null;
                slot_wdata.sum     = item_r.elem_is_null ? '0 : item_r.elem_value;
                pos_new            = pos + POS_W'(1);
              end else begin
                out_item_nxt.status = 1'b1;
              end
              meta_wdata.first = !item_r.elem_last;
              if (item_r.elem_last) begin
                len_new = pos_new;
                pos_new = '0;
              end
              out_valid_nxt = 1'b1;
            end else begin
              accept = (pos < meta_rd.len) &&
                       (!item_r.elem_last || (pos + POS_W'(1)) == meta_rd.len);
              if (accept) begin
                pos_new = pos + POS_W'(1);
              end
              if (item_r.elem_last) begin
                pos_new = '0;
              end
              if (accept && !item_r.elem_is_null) begin
                slot_raddr = slot_addr(g, pos);
                saddr_nxt  = slot_addr(g, pos);
                state_nxt  = ST_SLOT;
              end else begin
                out_item_nxt.status = !accept;
                out_valid_nxt       = 1'b1;
              end
            end
            meta_wdata.len = len_new;
            meta_wdata.pos = pos_new;
          end

          KIND_EMPTY: begin
            out_valid_nxt         = 1'b1;
            out_item_nxt.out_last = 1'b1;
            if (!cur_has) begin
              has_nxt[g]   = 1'b1;
              meta_we      = 1'b1;
              meta_wdata   = '0;
            end else begin
              out_item_nxt.status = !(!cur_first && meta_rd.len == '0);
            end
          end

          KIND_READ: begin
            has_nxt[g]   = 1'b0;
            if (cur_has && !cur_first && meta_rd.len != '0) begin
              slot_raddr = slot_addr(g, '0);
              idx_nxt    = '0;
              len_nxt    = meta_rd.len;
              state_nxt  = ST_READ;
            end else begin
              out_valid_nxt              = 1'b1;
              out_item_nxt.out_is_null   = 1'b1;
              out_item_nxt.group_is_null = 1'b1;
              out_item_nxt.out_last      = 1'b1;
            end
          end

          default: begin
            state_nxt = ST_IDLE;
          end
        endcase
      end

      ST_SLOT: begin
        slot_we               = 1'b1;
        slot_waddr            = saddr_r;
        slot_wdata.is_null    = 1'b0;
        slot_wdata.sum        = (slot_rd.is_null ? '0 : slot_rd.sum) + item_r.elem_value;
        out_valid_nxt         = 1'b1;
        out_item_nxt.out_last = 1'b1;
        state_nxt             = ST_IDLE;
      end

      ST_READ: begin
        out_valid_nxt            = 1'b1;
        out_item_nxt.out_value   = slot_rd.is_null ? '0 : slot_rd.sum;
        out_item_nxt.out_is_null = slot_rd.is_null;
        out_item_nxt.out_last    = rd_last;
        slot_raddr               = slot_addr(g, idx_r + POS_W'(1));
        idx_nxt                  = idx_r + POS_W'(1);
        if (rd_last) begin
          state_nxt = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign busy      = state_r != ST_IDLE;
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  a_read_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_READ |-> (len_r != '0) && (idx_r < len_r))
    else $error("read-out index outside stored length");

  a_slot_ack: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_SLOT |=> out_valid && out_item.out_last && !out_item.status)
    else $error("slot update not acknowledged");

  a_null_group: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.group_is_null |-> out_item.out_is_null && out_item.out_last)
    else $error("null group result malformed");

  a_accept: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> state_r == ST_META)
    else $error("accepted item not processed");

endmodule

[dv/grouped_array_elementwise_sum_core_tb.sv]
// ----------------------------------------------------------------------------
// Grouped array element-wise sum core: self-checking testbench
// Drives add, empty-array, read and unused-kind items with random gaps. It
// predicts every acknowledgment and read-out result of the per-group sums
// and compares each result that the core emits, field by field.
// ----------------------------------------------------------------------------
module grouped_array_elementwise_sum_core_tb import gaes_pkg::*;;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0]  KIND_UNUSED = 2'd3;
  localparam logic [63:0] VAL_MAX     = 64'h7fff_ffff_ffff_ffff;
  localparam logic [63:0] VAL_MIN     = 64'h8000_0000_0000_0000;
  localparam logic [63:0] VAL_NEG1    = 64'hffff_ffff_ffff_ffff;
  localparam int          RAND_ITEMS  = 460;
  localparam int          DRAIN_WAIT  = 40;

  typedef struct {
    in_item_t item;
    bit       hold;
  } pending_t;

  logic      clk     = 1'b0;
  logic      rst_n   = 1'b0;
  logic      start   = 1'b0;
  in_item_t  in_item = '0;
  logic      busy;
  logic      out_valid;
  out_item_t out_item;

  pending_t  item_q[$];
  out_item_t sum_result_q[$];

  // Predicted state of every group and slot.
  bit          grp_has[GROUPS];
  bit          grp_first[GROUPS];
  logic [4:0]  grp_len[GROUPS];
  logic [4:0]  grp_pos[GROUPS];
  logic [63:0] slot_acc[SLOTS];
  bit          slot_nul[SLOTS];

  // Stimulus-side view of the groups, used to shape well-formed arrays.
  bit          gen_has[GROUPS];
  bit          gen_first[GROUPS];
  int          gen_cnt[GROUPS];
  int          gen_len[GROUPS];
  logic [7:0]  group_pool[8];

  int items_total;
  int items_sent;
  int reads_sent;
  int results_seen;
  int mismatches;
  int idle_left;
  bit burst;
  pending_t cur;

  grouped_array_elementwise_sum_core u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_item (out_item)
  );

  always #10 clk = ~clk;

  function automatic void accumulate_item(in_item_t it);
    logic [7:0] g;
    logic [4:0] p;
    int         s;
    bit         ok;
    out_item_t  r;
    g = it.group_id;
    p = grp_pos[g];
    r = '0;
    r.out_last = 1'b1;
    case (it.kind)
      KIND_ADD: begin
        if (!grp_has[g]) begin
          grp_has[g] = 1'b1;
          grp_first[g] = 1'b1;
          p = '0;
        end
        s = int'(g) * MAX_LEN + int'(p);
        if (grp_first[g]) begin
          ok = p < MAX_LEN;
          if (ok) begin
            slot_nul[s] = it.elem_is_null;
            slot_acc[s] = it.elem_is_null ? 64'd0 : it.elem_value;
            p++;
          end
          if (it.elem_last) begin
            grp_len[g] = p;
            grp_first[g] = 1'b0;
            p = '0;
          end
        end else begin
          ok = (p < grp_len[g]) && (!it.elem_last || (p + 1 == grp_len[g]));
          if (ok) begin
            if (!it.elem_is_null) begin
              slot_acc[s] = (slot_nul[s] ? 64'd0 : slot_acc[s]) + it.elem_value;
              slot_nul[s] = 1'b0;
            end
            p++;
          end
          if (it.elem_last) p = '0;
        end
        grp_pos[g] = p;
        r.status = !ok;
        sum_result_q.insert(sum_result_q.size(), r);
      end
      KIND_EMPTY: begin
        if (!grp_has[g]) begin
          grp_has[g] = 1'b1;
          grp_first[g] = 1'b0;
          grp_len[g] = '0;
          grp_pos[g] = '0;
        end else begin
          r.status = grp_first[g] || (grp_len[g] != 0);
        end
        sum_result_q.insert(sum_result_q.size(), r);
      end
      KIND_READ: begin
        if (grp_has[g] && !grp_first[g] && grp_len[g] != 0) begin
          for (int i = 0; i < grp_len[g]; i++) begin
            s = int'(g) * MAX_LEN + i;
            r.out_is_null = slot_nul[s];
            r.out_value = slot_nul[s] ? 64'd0 : slot_acc[s];
            r.out_last = (i + 1 == grp_len[g]);
            sum_result_q.insert(sum_result_q.size(), r);
          end
        end else begin
          r.out_is_null = 1'b1;
          r.group_is_null = 1'b1;
          sum_result_q.insert(sum_result_q.size(), r);
        end
        grp_has[g] = 1'b0;
        grp_first[g] = 1'b0;
        grp_pos[g] = '0;
      end
      default: begin
      end
    endcase
  endfunction

  function automatic logic [63:0] rand_value();
    case ($urandom_range(0, 5))
      0: rand_value = 64'd0;
      1: rand_value = VAL_NEG1;
      2: rand_value = VAL_MAX;
      3: rand_value = VAL_MIN;
      4: rand_value = 64'($signed($urandom_range(0, 200)) - 100);
      default: rand_value = {$urandom, $urandom};
    endcase
  endfunction

  function automatic void queue_item(logic [1:0] kind, logic [7:0] g, logic [63:0] v,
                                     bit nul, bit last, bit hold);
    pending_t pi;
    case (kind)
      KIND_ADD: begin
        if (!gen_has[g]) begin
          gen_has[g] = 1'b1;
          gen_first[g] = 1'b1;
          gen_cnt[g] = 0;
        end
        if (gen_first[g]) begin
          if (gen_cnt[g] < MAX_LEN) gen_cnt[g]++;
          if (last) begin
            gen_len[g] = gen_cnt[g];
            gen_first[g] = 1'b0;
          end
        end
      end
      KIND_EMPTY: begin
        if (!gen_has[g]) begin
          gen_has[g] = 1'b1;
          gen_first[g] = 1'b0;
          gen_len[g] = 0;
        end
      end
      KIND_READ: begin
        gen_has[g] = 1'b0;
        gen_first[g] = 1'b0;
      end
      default: begin
      end
    endcase
    pi.item.kind = kind;
    pi.item.group_id = g;
    pi.item.elem_value = v;
    pi.item.elem_is_null = nul;
    pi.item.elem_last = last;
    pi.hold = hold;
    item_q.insert(item_q.size(), pi);
  endfunction

  function automatic void queue_array(logic [7:0] g, int len);
    if (len == 0) begin
      queue_item(KIND_EMPTY, g, rand_value(), $urandom_range(0, 1), $urandom_range(0, 1), 0);
    end else begin
      for (int i = 0; i < len; i++)
        queue_item(KIND_ADD, g, rand_value(), $urandom_range(0, 4) == 0, i == len - 1, 0);
    end
  endfunction

  function automatic logic [7:0] pick_group();
    if ($urandom_range(0, 9) == 0) pick_group = 8'($urandom_range(0, 255));
    else pick_group = group_pool[$urandom_range(0, 7)];
  endfunction

  function automatic int rand_len();
    int c;
    c = $urandom_range(0, 19);
    if (c == 0) rand_len = $urandom_range(MAX_LEN + 1, MAX_LEN + 2);
    else if (c < 3) rand_len = $urandom_range(5, MAX_LEN);
    else rand_len = $urandom_range(1, 4);
  endfunction

  task automatic check_field(string name, logic [63:0] exp_v, logic [63:0] got_v);
    if (got_v !== exp_v) begin
      $error("%s mismatch: expected %h, actual %h", name, exp_v, got_v);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
      idle_left = 0;
    end else begin
      if (start && !busy) begin
        accumulate_item(in_item);
        items_sent++;
        if (in_item.kind == KIND_READ) reads_sent++;
        if ($urandom_range(0, 29) == 0) burst = !burst;
        idle_left = burst ? 0 : $urandom_range(0, 19);
      end
      if (!start || !busy) begin
        if (idle_left > 0) begin
          idle_left--;
          start <= 1'b0;
        end else if (item_q.size() != 0 && !(item_q[0].hold && sum_result_q.size() != 0)) begin
          cur = item_q.pop_front();
          in_item <= cur.item;
          start <= 1'b1;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid) begin
      results_seen++;
      if (sum_result_q.size() == 0) begin
        $error("result with no item pending: value %h", out_item.out_value);
        mismatches++;
      end else begin
        want = sum_result_q.pop_front();
        check_field("out_value", want.out_value, out_item.out_value);
        check_field("out_is_null", want.out_is_null, out_item.out_is_null);
        check_field("group_is_null", want.group_is_null, out_item.group_is_null);
        check_field("out_last", want.out_last, out_item.out_last);
        check_field("status", want.status, out_item.status);
      end
    end
  end

  initial begin
    #5ms;
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    int     r;
    int     len;
    logic [7:0] g;
    group_pool[0] = 8'h00;
    group_pool[1] = 8'hff;
    group_pool[2] = 8'haa;
    group_pool[3] = 8'h55;
    for (int i = 4; i < 8; i++) group_pool[i] = 8'($urandom_range(1, 254));

    queue_item(KIND_UNUSED, 8'h00, VAL_NEG1, 1, 1, 0);
    queue_item(KIND_READ, 8'h11, VAL_NEG1, 1, 1, 0);
    queue_item(KIND_EMPTY, 8'hff, 64'd0, 0, 0, 0);
    queue_item(KIND_EMPTY, 8'hff, VAL_MAX, 1, 1, 0);
    queue_item(KIND_READ, 8'hff, 64'd0, 0, 0, 0);
    queue_item(KIND_READ, 8'hff, VAL_MIN, 1, 1, 0);
    queue_item(KIND_ADD, 8'h00, VAL_MAX, 0, 0, 0);
    queue_item(KIND_ADD, 8'h00, 64'd0, 1, 0, 0);
    queue_item(KIND_ADD, 8'h00, VAL_MIN, 0, 1, 0);
    queue_item(KIND_ADD, 8'h00, VAL_NEG1, 0, 0, 0);
    queue_item(KIND_ADD, 8'h00, 64'd5, 0, 0, 0);
    queue_item(KIND_ADD, 8'h00, 64'd1, 0, 1, 0);
    queue_item(KIND_ADD, 8'h00, 64'd7, 0, 1, 0);
    queue_item(KIND_ADD, 8'h00, VAL_NEG1, 1, 0, 0);
    queue_item(KIND_ADD, 8'h00, 64'd1, 0, 0, 0);
    queue_item(KIND_ADD, 8'h00, 64'd1, 0, 0, 0);
    queue_item(KIND_ADD, 8'h00, 64'd1, 0, 1, 0);
    queue_item(KIND_EMPTY, 8'h00, 64'd0, 0, 0, 0);
    queue_item(KIND_READ, 8'h00, 64'd0, 0, 0, 1);
    queue_item(KIND_ADD, 8'h00, 64'd9, 0, 0, 0);
    queue_item(KIND_EMPTY, 8'h00, 64'd0, 0, 0, 0);
    queue_item(KIND_READ, 8'h00, 64'd0, 0, 0, 0);

    // An over-long first array opens the random part.
    queue_array(8'h55, MAX_LEN + 1);
    queue_item(KIND_READ, 8'h55, 64'd0, 0, 0, 0);

    while (item_q.size() < RAND_ITEMS) begin
      g = pick_group();
      r = $urandom_range(0, 99);
      if (r < 50) begin
        if (gen_has[g] && !gen_first[g]) len = gen_len[g];
        else if (gen_has[g]) len = $urandom_range(1, 3);
        else len = rand_len();
        if ($urandom_range(0, 9) == 0) len = (len == 0 || $urandom_range(0, 1)) ? len + 1 : len - 1;
        queue_array(g, len);
      end else if (r < 58) begin
        queue_item(KIND_EMPTY, g, rand_value(), $urandom_range(0, 1), $urandom_range(0, 1), 0);
      end else if (r < 80) begin
        queue_item(KIND_READ, g, rand_value(), $urandom_range(0, 1), $urandom_range(0, 1),
                   $urandom_range(0, 7) == 0);
      end else begin
        queue_item(2'($urandom_range(0, 3)), g, rand_value(), $urandom_range(0, 1),
                   $urandom_range(0, 1), 0);
      end
    end
    items_total = item_q.size();

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    while (items_sent < items_total) @(posedge clk);
    while (sum_result_q.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    $display("Drove %0d items, %0d of them read-outs, over a pool of groups with gaps.",
             items_sent, reads_sent);
    $display("Checked %0d results; %0d field mismatches.", results_seen, mismatches);
    if (mismatches == 0 && sum_result_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
